// ===== rtl/sliding_window_rate_limiter_top_macros.svh =====
// Assertion macros for the sliding window rate limiter.
// Used by the top level only; the checks compile away when SYNTHESIS is set.
`ifndef SLIDING_WINDOW_RATE_LIMITER_TOP_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SWRL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rate limiter check failed: same-cycle implication");
`define SWRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rate limiter check failed: next-cycle implication");
`else
`define SWRL_ASSERT_IMPL(label, ante, cons)
`define SWRL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/swrl_pkg.sv =====
// Shared types, constants and ring arithmetic for the sliding window rate limiter.
// No dependencies; imported by the controller, the datapath and the top level.
package swrl_pkg;

  localparam int NUM_RULES = 4;
  localparam int BUCKETS   = 256;
  localparam int REG_RULES = 4;

  localparam int RULE_W    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int SLOT_W    = $clog2(BUCKETS);
  localparam int USED_W    = SLOT_W + 1;
  localparam int ADDR_W    = RULE_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int STAMP_W   = 32;
  localparam int HIT_W     = 16;
  localparam int WIN_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int REG_SEL_W = $clog2(REG_RULES);

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT0  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW0 = CFG_IDX_W'(REG_RULES);

  localparam logic [HIT_W-1:0] LIMIT_RESET  = HIT_W'(100);
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60);
  localparam logic [HIT_W-1:0] HIT_MAX      = {HIT_W{1'b1}};

  localparam logic ACT_CHECK  = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  typedef enum logic [1:0] {
    OUT_PASS   = 2'd0,
    OUT_DENY   = 2'd1,
    OUT_RECORD = 2'd2,
    OUT_NORULE = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    RD_OLDEST,
    RD_NEWEST,
    RD_PROBE
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DROP_RD,
    ST_DROP_CMP,
    ST_REC_RD,
    ST_REC_CMP,
    ST_REC_APP,
    ST_CHK_RD,
    ST_CHK_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [HIT_W-1:0]   hits;
  } bucket_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    drop;
    logic    acc;
    logic    bump;
    logic    append;
    logic    commit;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic action;
    logic rule_ok;
    logic used_zero;
    logic k_zero;
    logic k_one;
    logic is_old;
    logic same_sec;
    logic sum_over;
    logic out_free;
  } dp_stat_t;

  function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (SLOT_W+1)'(BUCKETS)) begin
      s = s - (SLOT_W+1)'(BUCKETS);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/sliding_window_rate_limiter_top.sv =====
// Channel     Handshake             Payload
// in          in_valid / in_ready   action, rule_found, rule_index, now_seconds
// out         out_valid / out_ready outcome, window_count
// cfg         cfg_wr_en             cfg_index, cfg_data (no wait, no read-back)
//
// One item at a time; the single-port bucket memory with its registered read costs a read
// state and then a compare or accumulate state per bucket visited. A check visits the s buckets
// it sums and the d buckets it drops; a record visits the d buckets it drops, then the newest one.
// Reset clears the ring pointers and loads the register defaults; bucket contents stay
// undefined. A new item is taken while a result waits; a stalled output holds only the
// finishing step of the following item.
`include "sliding_window_rate_limiter_top_macros.svh"
module sliding_window_rate_limiter_top
  import swrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic                 in_rule_found,
  input  logic [1:0]           in_rule_index,
  input  logic [STAMP_W-1:0]   in_now_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_outcome,
  output logic [HIT_W-1:0]     out_window_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  swrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swrl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_rule_found    (in_rule_found),
    .in_rule_index    (in_rule_index),
    .in_now_seconds   (in_now_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_window_count (out_window_count),
    .cmd              (cmd),
    .stat             (stat)
  );

  `SWRL_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `SWRL_ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, stat.out_free)
  `SWRL_ASSERT_IMPL(a_single_mem_write, cmd.bump, !cmd.append)

endmodule

// ===== rtl/swrl_ctrl.sv =====
// Sequencing state machine for the sliding window rate limiter.
// Depends on swrl_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module swrl_ctrl
  import swrl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_OLDEST;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!stat.rule_ok) begin
          state_nxt = ST_FIN;
        end else if (stat.action == ACT_RECORD) begin
          state_nxt = ST_DROP_RD;
        end else begin
          state_nxt = ST_CHK_RD;
        end
      end
      ST_DROP_RD: begin
        if (stat.used_zero) begin
          state_nxt = (stat.action == ACT_RECORD) ? ST_REC_RD : ST_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_OLDEST;
          state_nxt  = ST_DROP_CMP;
        end
      end
      ST_DROP_CMP: begin
        if (stat.is_old) begin
          cmd.drop  = 1'b1;
          state_nxt = ST_DROP_RD;
        end else begin
          state_nxt = (stat.action == ACT_RECORD) ? ST_REC_RD : ST_FIN;
        end
      end
      ST_REC_RD: begin
        if (stat.used_zero) begin
          state_nxt = ST_REC_APP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEWEST;
          state_nxt  = ST_REC_CMP;
        end
      end
      ST_REC_CMP: begin
        if (stat.same_sec) begin
          cmd.bump  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_REC_APP;
        end
      end
      ST_REC_APP: begin
        cmd.append = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_CHK_RD: begin
        if (stat.k_zero) begin
          state_nxt = ST_DROP_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PROBE;
          state_nxt  = ST_CHK_ACC;
        end
      end
      ST_CHK_ACC: begin
        if (stat.is_old) begin
          state_nxt = ST_DROP_RD;
        end else begin
          cmd.acc   = 1'b1;
          state_nxt = (stat.sum_over || stat.k_one) ? ST_DROP_RD : ST_CHK_RD;
        end
      end
      ST_FIN: begin
        cmd.commit = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/swrl_dp.sv =====
// Datapath of the sliding window rate limiter: bucket memory, ring pointers,
// configuration registers, window sum and result register. Depends on swrl_pkg.
module swrl_dp
  import swrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_action,
  input  logic                 in_rule_found,
  input  logic [1:0]           in_rule_index,
  input  logic [STAMP_W-1:0]   in_now_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_outcome,
  output logic [HIT_W-1:0]     out_window_count,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);

  bucket_t mem [MEM_DEPTH];
  bucket_t rd_data_r;

  logic [HIT_W-1:0]  limit_r  [REG_RULES];
  logic [WIN_W-1:0]  window_r [REG_RULES];
  logic [SLOT_W-1:0] oldest_slot_r [NUM_RULES];
  logic [USED_W-1:0] slots_used_r  [NUM_RULES];

  logic               action_r;
  logic               rule_ok_r;
  logic [RULE_W-1:0]  rule_r;
  logic [STAMP_W-1:0] now_r;
  logic [WIN_W-1:0]   win_r;
  logic [HIT_W-1:0]   lim_r;
  logic [SLOT_W-1:0]  oldest_r;
  logic [USED_W-1:0]  used_r;
  logic [USED_W-1:0]  k_r;
  logic [HIT_W-1:0]   sum_r;

  logic               out_valid_r;
  outcome_t           outcome_r;
  logic [HIT_W-1:0]   out_count_r;

  logic [USED_W-1:0]  used_m1;
  logic [USED_W-1:0]  k_m1;
  logic               full;
  logic [SLOT_W-1:0]  newest_slot;
  logic [SLOT_W-1:0]  probe_slot;
  logic [SLOT_W-1:0]  app_slot;
  logic [SLOT_W-1:0]  rd_slot;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_en;
  bucket_t            wr_data;
  logic [HIT_W:0]     sum_wide;
  logic [HIT_W-1:0]   sum_sat;
  logic [STAMP_W:0]   stamp_end;
  logic [HIT_W-1:0]   hits_inc;
  logic               rule_ok_in;
  outcome_t           outcome_nxt;

  assign used_m1     = used_r - USED_W'(1);
  assign k_m1        = k_r - USED_W'(1);
  assign full        = (used_r == USED_W'(BUCKETS));
  assign newest_slot = ring_add(oldest_r, used_m1[SLOT_W-1:0]);
  assign probe_slot  = ring_add(oldest_r, k_m1[SLOT_W-1:0]);
  assign app_slot    = ring_add(oldest_r, full ? '0 : used_r[SLOT_W-1:0]);

  always_comb begin
    case (cmd.rd_sel)
      RD_OLDEST: rd_slot = oldest_r;
      RD_NEWEST: rd_slot = newest_slot;
      RD_PROBE:  rd_slot = probe_slot;
      default:   rd_slot = oldest_r;
    endcase
  end

  assign rd_addr  = {rule_r, rd_slot};
  assign wr_addr  = {rule_r, cmd.append ? app_slot : newest_slot};
  assign wr_en    = cmd.bump || cmd.append;
  assign hits_inc = (rd_data_r.hits == HIT_MAX) ? HIT_MAX : rd_data_r.hits + HIT_W'(1);

  always_comb begin
    if (cmd.append) begin
      wr_data.stamp = now_r;
      wr_data.hits  = HIT_W'(1);
    end else begin
      wr_data.stamp = rd_data_r.stamp;
      wr_data.hits  = hits_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign stamp_end = {1'b0, rd_data_r.stamp} + (STAMP_W+1)'(win_r);
  assign sum_wide  = {1'b0, sum_r} + {1'b0, rd_data_r.hits};
  assign sum_sat   = sum_wide[HIT_W] ? HIT_MAX : sum_wide[HIT_W-1:0];

  assign rule_ok_in = in_rule_found && (32'(in_rule_index) < NUM_RULES)
                      && (32'(in_rule_index) < REG_RULES);

  always_comb begin
    if (!rule_ok_r) begin
      outcome_nxt = OUT_NORULE;
    end else if (action_r == ACT_RECORD) begin
      outcome_nxt = OUT_RECORD;
    end else if (sum_r >= lim_r) begin
      outcome_nxt = OUT_DENY;
    end else begin
      outcome_nxt = OUT_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_RULES; i++) begin
        limit_r[i]  <= LIMIT_RESET;
        window_r[i] <= WINDOW_RESET;
      end
      for (int i = 0; i < NUM_RULES; i++) begin
        oldest_slot_r[i] <= '0;
        slots_used_r[i]  <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index < REG_WINDOW0) begin
          limit_r[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
        end else if (cfg_index >= REG_WINDOW0) begin
          window_r[cfg_index[REG_SEL_W-1:0]] <= cfg_data[WIN_W-1:0];
        end
      end
      if (cmd.commit && rule_ok_r) begin
        oldest_slot_r[rule_r] <= oldest_r;
        slots_used_r[rule_r]  <= used_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r  <= in_action;
      rule_ok_r <= rule_ok_in;
      rule_r    <= RULE_W'(in_rule_index);
      now_r     <= in_now_seconds;
      lim_r     <= limit_r[in_rule_index[REG_SEL_W-1:0]];
      win_r     <= window_r[in_rule_index[REG_SEL_W-1:0]];
      oldest_r  <= oldest_slot_r[RULE_W'(in_rule_index)];
      used_r    <= slots_used_r[RULE_W'(in_rule_index)];
      k_r       <= slots_used_r[RULE_W'(in_rule_index)];
      sum_r     <= '0;
    end else begin
      if (cmd.drop) begin
        oldest_r <= ring_add(oldest_r, SLOT_W'(1));
        used_r   <= used_m1;
      end
      if (cmd.append) begin
        if (full) begin
          oldest_r <= ring_add(oldest_r, SLOT_W'(1));
        end else begin
          used_r <= used_r + USED_W'(1);
        end
      end
      if (cmd.acc) begin
        sum_r <= sum_sat;
        k_r   <= k_m1;
      end
    end
    if (cmd.out_load) begin
      outcome_r   <= outcome_nxt;
      out_count_r <= (rule_ok_r && action_r == ACT_CHECK) ? sum_r : '0;
    end
  end

  assign stat.action    = action_r;
  assign stat.rule_ok   = rule_ok_r;
  assign stat.used_zero = (used_r == '0);
  assign stat.k_zero    = (k_r == '0);
  assign stat.k_one     = (k_r == USED_W'(1));
  assign stat.is_old    = ({1'b0, now_r} > stamp_end);
  assign stat.same_sec  = (rd_data_r.stamp == now_r);
  assign stat.sum_over  = (sum_sat > lim_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_window_count = out_count_r;

endmodule
